// File: rtl/swmmm_pkg.sv
// Package for the sliding window minimum, mean and maximum block.
// Holds the sizing constants and the command and status structs that join
// the controller and the datapath. Depends on nothing.
package swmmm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WS_BITS     = 7;
    localparam int INDEX_BITS  = 32;
    localparam int MEAN_BITS   = 24;
    localparam int FRAC_BITS   = 8;

    localparam int PTR_BITS     = $clog2(WINDOW_MAX);
    localparam int CNT_BITS     = $clog2(WINDOW_MAX + 1);
    localparam int CMP_BITS     = (CNT_BITS > WS_BITS) ? CNT_BITS : WS_BITS;
    localparam int SUM_BITS     = SAMPLE_BITS + CNT_BITS;
    localparam int DVD_BITS     = SUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);
    localparam int OUT_BITS     = INDEX_BITS + 3 * SAMPLE_BITS + MEAN_BITS;
    localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;
    localparam int IN_BYTES     = (SAMPLE_BITS + 7) / 8;

    localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(4);

    typedef struct packed {
        logic accept;
        logic issue;
        logic div_init;
        logic div_step;
        logic out_load;
    } swmmm_cmd_t;

    typedef struct packed {
        logic issue_last;
        logic div_last;
        logic out_free;
    } swmmm_stat_t;

endpackage

// File: rtl/swmmm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Width and depth are parameters. Depends on nothing.
module swmmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/swmmm_ctrl.sv
// Controller state machine: accept, window scan, division, result hand-off.
// Depends on swmmm_pkg for the command and status structs.
module swmmm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  swmmm_pkg::swmmm_stat_t stat,
    output swmmm_pkg::swmmm_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (stat.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/swmmm_datapath.sv
// Datapath: history RAM, pointers and counters, min/max/sum scan,
// restoring divider and the result register.
// Depends on swmmm_pkg and swmmm_ram.
module swmmm_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  swmmm_pkg::swmmm_cmd_t                  cmd,
    output swmmm_pkg::swmmm_stat_t                 stat,
    input  logic signed [swmmm_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   cfg_we,
    input  logic [swmmm_pkg::WS_BITS-1:0]          cfg_wdata,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [swmmm_pkg::OUT_BYTES*8-1:0]      m_tdata
);

    localparam int SB  = swmmm_pkg::SAMPLE_BITS;
    localparam int PB  = swmmm_pkg::PTR_BITS;
    localparam int CB  = swmmm_pkg::CNT_BITS;
    localparam int MB  = swmmm_pkg::CMP_BITS;
    localparam int UB  = swmmm_pkg::SUM_BITS;
    localparam int DB  = swmmm_pkg::DVD_BITS;
    localparam int NB  = swmmm_pkg::DIV_CNT_BITS;
    localparam int EB  = swmmm_pkg::MEAN_BITS;
    localparam int IB  = swmmm_pkg::INDEX_BITS;
    localparam int WM  = swmmm_pkg::WINDOW_MAX;

    logic [swmmm_pkg::WS_BITS-1:0] ws_reg;
    logic [PB-1:0]        wptr_reg;
    logic [PB-1:0]        rptr_reg;
    logic [CB-1:0]        fill_reg;
    logic [CB-1:0]        span_reg;
    logic [CB-1:0]        left_reg;
    logic [IB-1:0]        count_reg;
    logic                 rd_valid_reg;
    logic signed [SB-1:0] x_reg;
    logic signed [SB-1:0] lo_reg;
    logic signed [SB-1:0] hi_reg;
    logic signed [UB-1:0] sum_reg;
    logic [DB-1:0]        dvd_reg;
    logic [CB-1:0]        rem_reg;
    logic                 neg_reg;
    logic [NB-1:0]        div_cnt_reg;
    logic                 m_tvalid_reg;
    logic [swmmm_pkg::OUT_BYTES*8-1:0] m_tdata_reg;

    logic [CB-1:0]        fill_next;
    logic [MB-1:0]        ws_eff;
    logic [CB-1:0]        span_next;
    logic signed [SB-1:0] rd_data;
    logic [UB-1:0]        sum_mag;
    logic [CB:0]          rem_shift;
    logic                 q_bit;
    logic [EB-1:0]        quot;
    logic [EB-1:0]        mean;

    swmmm_ram #(
        .WIDTH (SB),
        .DEPTH (WM)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (wptr_reg),
        .wdata (sample_in),
        .re    (cmd.issue),
        .raddr (rptr_reg),
        .rdata (rd_data)
    );

    always_comb begin
        fill_next = (fill_reg < CB'(WM)) ? fill_reg + CB'(1) : fill_reg;
        if (ws_reg == '0) begin
            ws_eff = MB'(1);
        end else if (MB'(ws_reg) > MB'(WM)) begin
            ws_eff = MB'(WM);
        end else begin
            ws_eff = MB'(ws_reg);
        end
        span_next = (ws_eff > MB'(fill_next)) ? fill_next : CB'(ws_eff);
    end

    always_comb begin
        sum_mag   = sum_reg[UB-1] ? UB'(-sum_reg) : UB'(sum_reg);
        rem_shift = {rem_reg, dvd_reg[DB-1]};
        q_bit     = (rem_shift >= {1'b0, span_reg});
        quot      = dvd_reg[EB-1:0];
        mean      = neg_reg ? EB'(-quot) : quot;
    end

    assign stat.issue_last = (left_reg == CB'(1));
    assign stat.div_last   = (div_cnt_reg == NB'(1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg       <= swmmm_pkg::WS_RESET;
            wptr_reg     <= '0;
            fill_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                ws_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                wptr_reg  <= (wptr_reg == PB'(WM - 1)) ? '0 : wptr_reg + PB'(1);
                fill_reg  <= fill_next;
                count_reg <= count_reg + IB'(1);
            end
            rd_valid_reg <= cmd.issue;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_reg    <= sample_in;
            lo_reg   <= sample_in;
            hi_reg   <= sample_in;
            sum_reg  <= '0;
            rptr_reg <= wptr_reg;
            span_reg <= span_next;
            left_reg <= span_next;
        end
        if (cmd.issue) begin
            rptr_reg <= (rptr_reg == '0) ? PB'(WM - 1) : rptr_reg - PB'(1);
            left_reg <= left_reg - CB'(1);
        end
        if (rd_valid_reg) begin
            if (rd_data < lo_reg) begin
                lo_reg <= rd_data;
            end
            if (rd_data > hi_reg) begin
                hi_reg <= rd_data;
            end
            sum_reg <= sum_reg + UB'(rd_data);
        end
        if (cmd.div_init) begin
            dvd_reg     <= {sum_mag, {swmmm_pkg::FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
            neg_reg     <= sum_reg[UB-1];
            div_cnt_reg <= NB'(DB);
        end
        if (cmd.div_step) begin
            rem_reg     <= q_bit ? CB'(rem_shift - {1'b0, span_reg}) : CB'(rem_shift);
            dvd_reg     <= {dvd_reg[DB-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg - NB'(1);
        end
        if (cmd.out_load) begin
            m_tdata_reg <= (swmmm_pkg::OUT_BYTES*8)'({hi_reg, mean, lo_reg, x_reg, count_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/sliding_window_min_mean_max.sv
// Top level of the sliding window minimum, mean and maximum block.
// Joins swmmm_ctrl and swmmm_datapath; depends on swmmm_pkg.
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: sample_value
// m_        out  m_tvalid/m_tready    m_tdata: index, echo, min, mean, max
// cfg_      in   cfg_we               cfg_wdata: window_size
//
// A request runs through these steps in order: accept, one RAM read per entry of
// the effective window, a drain of the read port, a divider load, 31 divide steps
// and the result load. Reset is synchronous and active low.
// A result that waits on m_tready holds only the hand-off; the scan runs ahead.
module sliding_window_min_mean_max (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] sample_value
    input  logic [swmmm_pkg::IN_BYTES*8-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] sample_index, [47:32] value_echo, [63:48] window_minimum,
    // [87:64] window_mean, [103:88] window_maximum
    output logic [swmmm_pkg::OUT_BYTES*8-1:0]      m_tdata,
    input  logic                                   cfg_we,
    input  logic [swmmm_pkg::WS_BITS-1:0]          cfg_wdata
);

    swmmm_pkg::swmmm_cmd_t  cmd;
    swmmm_pkg::swmmm_stat_t stat;

    swmmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swmmm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .sample_in (s_tdata[swmmm_pkg::SAMPLE_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/swmmm_checker.sv
// Port-level checker for the sliding window block, bound to the top level.
// Depends on swmmm_pkg for the port widths.
module swmmm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [swmmm_pkg::OUT_BYTES*8-1:0] m_tdata
);

    logic signed [15:0] echo_w;
    logic signed [15:0] lo_w;
    logic signed [15:0] hi_w;

    assign echo_w = m_tdata[47:32];
    assign lo_w   = m_tdata[63:48];
    assign hi_w   = m_tdata[103:88];

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("new request taken while one is in work");

    a_min_max_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lo_w <= echo_w) && (echo_w <= hi_w))
        else $error("sample outside the reported window range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind sliding_window_min_mean_max swmmm_checker u_swmmm_checker (.*);

// File: tb/tb.sv
// Testbench for sliding_window_min_mean_max: drives random and directed samples
// over the stream ports, predicts min, mean and max per request and checks them.
// Depends on swmmm_pkg and the block under test.
module tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_SAMPLES = 1600;
    localparam int SB = swmmm_pkg::SAMPLE_BITS;
    localparam int WM = swmmm_pkg::WINDOW_MAX;

    typedef logic [swmmm_pkg::SAMPLE_BITS-1:0] sample_t;
    typedef logic [swmmm_pkg::WS_BITS-1:0]     wsize_t;

    typedef struct packed {
        logic [swmmm_pkg::SAMPLE_BITS-1:0] window_maximum;
        logic [swmmm_pkg::MEAN_BITS-1:0]   window_mean;
        logic [swmmm_pkg::SAMPLE_BITS-1:0] window_minimum;
        logic [swmmm_pkg::SAMPLE_BITS-1:0] value_echo;
        logic [swmmm_pkg::INDEX_BITS-1:0]  sample_index;
    } window_stats_t;

    class window_stats_board;
        window_stats_t                    expected_stats[$];
        sample_t                          history[WM];
        int unsigned                      head;
        int unsigned                      filled;
        int unsigned                      mismatch_count;
        int unsigned                      result_count;
        logic [swmmm_pkg::INDEX_BITS-1:0] sample_count;
        wsize_t                           window_size;

        function new();
            head = 0;
            filled = 0;
            mismatch_count = 0;
            result_count = 0;
            sample_count = '0;
            window_size = swmmm_pkg::WS_RESET;
        endfunction

        function void set_window(wsize_t size);
            window_size = size;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        function void note_sample(sample_t raw);
            window_stats_t        stats;
            logic signed [SB-1:0] lo;
            logic signed [SB-1:0] hi;
            logic signed [SB-1:0] entry;
            int unsigned          span;
            int unsigned          pos;
            longint               sum;
            longint               mean;
            history[head] = raw;
            pos = head;
            head = (head + 1) % WM;
            if (filled < WM) filled++;
            sample_count++;
            span = int'(window_size);
            if (span == 0) span = 1;
            if (span > WM) span = WM;
            if (span > filled) span = filled;
            lo = raw;
            hi = raw;
            sum = 0;
            for (int k = 0; k < span; k++) begin
                entry = history[pos];
                if (entry < lo) lo = entry;
                if (entry > hi) hi = entry;
                sum += entry;
                pos = (pos == 0) ? WM - 1 : pos - 1;
            end
            mean = (sum * 256) / longint'(span);
            stats.sample_index = sample_count;
            stats.value_echo = raw;
            stats.window_minimum = lo;
            stats.window_maximum = hi;
            stats.window_mean = mean[swmmm_pkg::MEAN_BITS-1:0];
            expected_stats.push_back(stats);
        endfunction

        task report(string what);
            mismatch_count++;
            if (mismatch_count <= 100) $display("MISMATCH at result %0d: %s", result_count, what);
        endtask

        task check_result(logic [swmmm_pkg::OUT_BYTES*8-1:0] data);
            window_stats_t got;
            window_stats_t want;
            got = data[swmmm_pkg::OUT_BITS-1:0];
            result_count++;
            if (expected_stats.size() == 0) begin
                report("result with no request pending");
                return;
            end
            want = expected_stats.pop_front();
            if (got.sample_index != want.sample_index)
                report($sformatf("sample_index got %0d want %0d",
                                 got.sample_index, want.sample_index));
            if (got.value_echo != want.value_echo)
                report($sformatf("value_echo got %0d want %0d",
                                 $signed(got.value_echo), $signed(want.value_echo)));
            if (got.window_minimum != want.window_minimum)
                report($sformatf("window_minimum got %0d want %0d",
                                 $signed(got.window_minimum), $signed(want.window_minimum)));
            if (got.window_mean != want.window_mean)
                report($sformatf("window_mean got %0d want %0d",
                                 $signed(got.window_mean), $signed(want.window_mean)));
            if (got.window_maximum != want.window_maximum)
                report($sformatf("window_maximum got %0d want %0d",
                                 $signed(got.window_maximum), $signed(want.window_maximum)));
        endtask
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [swmmm_pkg::IN_BYTES*8-1:0]    s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [swmmm_pkg::OUT_BYTES*8-1:0]   m_tdata;
    logic                                cfg_we;
    wsize_t                              cfg_wdata;

    window_stats_board board;
    bit                tx_eager = 1'b0;
    bit                rx_eager = 1'b0;
    int                long_hold = 0;

    sliding_window_min_mean_max dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic sample_t pick_sample(int style, int k, sample_t base);
        case (style)
            0: return sample_t'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return sample_t'($urandom);
                endcase
            end
            2: return base + sample_t'($urandom_range(0, 15)) - sample_t'(8);
            default: return base + sample_t'(k * 97);
        endcase
    endfunction

    task automatic send_sample(input sample_t value);
        int gap;
        gap = tx_eager ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_window(input wsize_t size);
        drain_results();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        board.set_window(size);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_sample(s_tdata[SB-1:0]);
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold > 0) begin
                hold = long_hold;
                long_hold = 0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (rx_eager) begin
                m_tready <= 1'b1;
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    m_tready <= 1'b0;
                    hold--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int      sent;
        int      phase_len;
        int      style;
        int      phase_no;
        wsize_t  size;
        sample_t base;
        board = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Warm-up under the reset window, then under the widest window.
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        write_window(7'd64);
        send_sample(16'h7fff);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        // A zero window acts as one sample; oversize windows clamp to the store.
        write_window(7'd0);
        send_sample(16'd100);
        send_sample(-16'sd100);
        send_sample(16'd7);
        write_window(7'd65);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h1234);
        write_window(7'd127);
        send_sample(16'hfffe);
        send_sample(16'h0003);
        write_window(7'd1);
        send_sample(16'h0000);
        send_sample(16'hffff);
        // Negative sums that do not divide evenly must truncate toward zero.
        write_window(7'd3);
        send_sample(16'hffff);
        send_sample(16'h0000);
        send_sample(16'h0000);

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_SAMPLES) begin
            phase_no++;
            case ($urandom_range(0, 9))
                0: size = 7'd0;
                1: size = 7'd1;
                2: size = 7'd2;
                3: size = 7'd4;
                4: size = 7'd63;
                5: size = 7'd64;
                6: size = 7'd65;
                7: size = 7'd127;
                default: size = wsize_t'($urandom_range(0, 127));
            endcase
            write_window(size);
            phase_len = $urandom_range(20, 150);
            style = $urandom_range(0, 3);
            base = sample_t'($urandom);
            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager = ($urandom_range(0, 4) == 0);
            if (phase_no == 3) begin
                tx_eager = 1'b1;
                long_hold = 400;
            end
            for (int k = 0; k < phase_len; k++) begin
                send_sample(pick_sample(style, k, base));
                sent++;
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (board.mismatch_count == 0 && board.pending() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: sim.f
rtl/swmmm_pkg.sv
rtl/swmmm_ram.sv
rtl/swmmm_ctrl.sv
rtl/swmmm_datapath.sv
rtl/sliding_window_min_mean_max.sv
rtl/swmmm_checker.sv
tb/tb.sv
